>>> rtl/core/smfc_pkg.sv
// Shared types, register map and helpers for the SPI master FIFO controller.
// No dependencies.
package smfc_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_SPARE = 2'd3
  } cmd_t;

  localparam logic [11:0] ADDR_CTRL   = 12'h000;
  localparam logic [11:0] ADDR_ENABLE = 12'h008;
  localparam logic [11:0] ADDR_SSEL   = 12'h00C;
  localparam logic [11:0] ADDR_BAUD   = 12'h010;
  localparam logic [11:0] ADDR_TXTH   = 12'h014;
  localparam logic [11:0] ADDR_RXTH   = 12'h018;
  localparam logic [11:0] ADDR_TXLVL  = 12'h01C;
  localparam logic [11:0] ADDR_RXLVL  = 12'h020;
  localparam logic [11:0] ADDR_STATUS = 12'h024;
  localparam logic [11:0] ADDR_POL    = 12'h028;
  localparam logic [11:0] ADDR_MASK   = 12'h02C;
  localparam logic [11:0] ADDR_ISR    = 12'h030;
  localparam logic [11:0] ADDR_RISR   = 12'h034;
  localparam logic [11:0] ADDR_ICLR   = 12'h038;
  localparam logic [11:0] ADDR_TXDATA = 12'h400;
  localparam logic [11:0] ADDR_RXDATA = 12'h800;

  localparam int unsigned SLAVE_COUNT = 2;
  localparam logic [1:0]  SEL_MASK    = 2'(((1 << SLAVE_COUNT) - 1) & 3);

  typedef struct packed {
    logic flush;
    logic push;
    logic pop;
  } fifo_ctrl_t;

  // Frame length mask for size code (0: 4, 1: 8, else 16 bits).
  function automatic logic [15:0] frame_mask(input logic [1:0] code);
    logic [15:0] m;
    unique case (code)
      2'd0:    m = 16'h000F;
      2'd1:    m = 16'h00FF;
      default: m = 16'hFFFF;
    endcase
    return m;
  endfunction

  function automatic logic [4:0] frame_len(input logic [1:0] code);
    logic [4:0] n;
    unique case (code)
      2'd0:    n = 5'd4;
      2'd1:    n = 5'd8;
      default: n = 5'd16;
    endcase
    return n;
  endfunction

  // Mirror the low frame bits of a word.
  function automatic logic [15:0] frame_rev(input logic [15:0] d, input logic [1:0] code);
    logic [15:0] r;
    r = '0;
    unique case (code)
      2'd0: for (int i = 0; i < 4; i++) r[3-i] = d[i];
      2'd1: for (int i = 0; i < 8; i++) r[7-i] = d[i];
      default: for (int i = 0; i < 16; i++) r[15-i] = d[i];
    endcase
    return r;
  endfunction

  // Top bit of the current frame, the MOSI level.
  function automatic logic frame_msb(input logic [15:0] d, input logic [1:0] code);
    logic b;
    unique case (code)
      2'd0:    b = d[3];
      2'd1:    b = d[7];
      default: b = d[15];
    endcase
    return b;
  endfunction

endpackage

>>> rtl/core/smfc_if.sv
// Valid/ready channel interfaces for the SPI master FIFO controller.
// Depends on nothing.
interface smfc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [11:0] address;
  logic [21:0] write_data;
  logic        miso;
  modport source (output valid, command, address, write_data, miso, input ready);
  modport sink   (input valid, command, address, write_data, miso, output ready);
endinterface

interface smfc_out_if;
  logic        valid;
  logic        ready;
  logic [21:0] read_data;
  logic        sclk;
  logic        mosi;
  logic [1:0]  cs_n;
  logic        irq;
  modport source (output valid, read_data, sclk, mosi, cs_n, irq, input ready);
  modport sink   (input valid, read_data, sclk, mosi, cs_n, irq, output ready);
endinterface

>>> rtl/core/smfc_fifo.sv
// Circular word FIFO with a prefetched head entry.
// Depends on smfc_pkg (fifo_ctrl_t).
module smfc_fifo #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  smfc_pkg::fifo_ctrl_t         ctrl,
  input  logic [15:0]                  push_data,
  output logic [$clog2(DEPTH+1)-1:0]   count,
  output logic [15:0]                  front
);
  import smfc_pkg::*;

  localparam int unsigned HW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [15:0]   mem [DEPTH];
  logic [HW-1:0] head_r, head_nxt, widx;
  logic [CW-1:0] count_r, count_nxt;
  logic [15:0]   front_r;
  logic [HW:0]   wsum;

  // Write slot is head + count either side of a pop in the same tick.
  assign wsum = {1'b0, head_r} + (HW+1)'(count_r);
  assign widx = (wsum >= (HW+1)'(DEPTH)) ? HW'(wsum - (HW+1)'(DEPTH)) : HW'(wsum);

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (ctrl.flush) begin
      head_nxt  = '0;
      count_nxt = '0;
    end else begin
      if (ctrl.pop) begin
        head_nxt = (head_r == HW'(DEPTH - 1)) ? '0 : HW'(head_r + 1'b1);
      end
      count_nxt = CW'(count_r + CW'(ctrl.push) - CW'(ctrl.pop));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[widx] <= push_data;
    end
    if (ctrl.push && widx == head_nxt) begin
      front_r <= push_data;
    end else begin
      front_r <= mem[head_nxt];
    end
  end

  // An empty FIFO pushed and popped in one tick hands the new word straight on.
  assign count = count_r;
  assign front = (count_r == '0) ? push_data : front_r;

endmodule

>>> rtl/core/spi_master_fifo_controller_unit.sv
// SPI master FIFO controller top level: register file, shifter, output stage.
// Depends on smfc_pkg, smfc_in_if / smfc_out_if and smfc_fifo.
//
// Usage: every transfer on in_ch is one bus tick. It carries an optional
// register read or write (command, address, write_data) and the MISO level
// sampled on that tick. For every input transfer exactly one transfer leaves
// on out_ch with the read data, SCLK, MOSI, the active-low chip selects and
// the combined interrupt line as they stand after that tick.
// Each tick is offered on out_ch from the output register in the cycle after
// it is accepted. Throughput is one tick per cycle while out_ch.ready holds;
// the register access, FIFO update and shifter step all fit in one pass
// between the input handshake and the output register.
// The output register acts as the skid stage: a new tick is taken while the
// last result is being taken. When the receiver stalls, in_ch.ready drops and
// all state holds until the result leaves.
// Reset (rst_n low, synchronous) clears all but the result data registers,
// empties both FIFOs and stops the shifter; unwritten FIFO data is undefined.
module spi_master_fifo_controller_unit #(
  parameter int unsigned FIFO_DEPTH = 32
) (
  input logic         clk,
  input logic         rst_n,
  smfc_in_if.sink     in_ch,
  smfc_out_if.source  out_ch
);
  import smfc_pkg::*;

  localparam int unsigned CW   = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned CMPW = (CW > 5) ? CW : 5;

  // Programmed registers
  logic [21:0] ctrl_r,   ctrl_nxt;
  logic        en_r,     en_nxt;
  logic [1:0]  ssel_r,   ssel_nxt;
  logic [15:0] baud_r,   baud_nxt;
  logic [4:0]  txth_r,   txth_nxt;
  logic [4:0]  rxth_r,   rxth_nxt;
  logic [4:0]  imask_r,  imask_nxt;
  logic        ipol_r,   ipol_nxt;
  logic [2:0]  sticky_r, sticky_nxt;

  // Shifter state
  logic [15:0] sw_r,   sw_nxt;
  logic [4:0]  bits_r, bits_nxt;
  logic [15:0] cc_r,   cc_nxt;
  logic        sclk_r, sclk_nxt;
  logic        busy_r, busy_nxt;
  logic        held_r, held_nxt;

  // Result register
  logic        ovalid_r;
  logic [21:0] rdata_r, rdata_nxt;
  logic        osclk_r, osclk_nxt;
  logic        omosi_r, omosi_nxt;
  logic [1:0]  ocs_r,   ocs_nxt;
  logic        oirq_r,  oirq_nxt;

  logic          accept;
  fifo_ctrl_t    tx_ctl, rx_ctl;
  logic [15:0]   tx_wdata, rx_wdata, tx_front, rx_front;
  logic [CW-1:0] tx_count, rx_count;

  logic          flush, tx_push, tx_pop, rx_pop, rx_push;
  logic [CW-1:0] tx_cnt_a, rx_cnt_a, tx_cnt_f, rx_cnt_f;
  logic [14:0]   half;
  logic [15:0]   fmask, d;
  logic [4:0]    raw;

  assign in_ch.ready = !ovalid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  smfc_fifo #(.DEPTH(FIFO_DEPTH)) u_tx_fifo (
    .clk(clk), .rst_n(rst_n), .ctrl(tx_ctl), .push_data(tx_wdata),
    .count(tx_count), .front(tx_front)
  );

  smfc_fifo #(.DEPTH(FIFO_DEPTH)) u_rx_fifo (
    .clk(clk), .rst_n(rst_n), .ctrl(rx_ctl), .push_data(rx_wdata),
    .count(rx_count), .front(rx_front)
  );

  assign tx_wdata = in_ch.write_data[15:0];
  assign tx_ctl   = '{flush: accept && flush, push: accept && tx_push, pop: accept && tx_pop};
  assign rx_ctl   = '{flush: accept && flush, push: accept && rx_push, pop: accept && rx_pop};

  always_comb begin
    ctrl_nxt   = ctrl_r;
    en_nxt     = en_r;
    ssel_nxt   = ssel_r;
    baud_nxt   = baud_r;
    txth_nxt   = txth_r;
    rxth_nxt   = rxth_r;
    imask_nxt  = imask_r;
    ipol_nxt   = ipol_r;
    sticky_nxt = sticky_r;
    sw_nxt     = sw_r;
    bits_nxt   = bits_r;
    cc_nxt     = cc_r;
    sclk_nxt   = sclk_r;
    busy_nxt   = busy_r;
    held_nxt   = held_r;
    rdata_nxt  = '0;
    flush      = 1'b0;
    tx_push    = 1'b0;
    tx_pop     = 1'b0;
    rx_pop     = 1'b0;
    rx_push    = 1'b0;
    tx_cnt_a   = tx_count;
    rx_cnt_a   = rx_count;
    d          = '0;
    raw        = '0;

    // Register access sees the state at the start of the tick.
    raw[4] = CMPW'(rx_count) > CMPW'(rxth_r);
    raw[3] = sticky_r[2];
    raw[2] = sticky_r[1];
    raw[1] = sticky_r[0];
    raw[0] = CMPW'(tx_count) <= CMPW'(txth_r);

    if (in_ch.command == CMD_READ) begin
      unique case (in_ch.address)
        ADDR_CTRL:   rdata_nxt = ctrl_r;
        ADDR_ENABLE: rdata_nxt = 22'(en_r);
        ADDR_SSEL:   rdata_nxt = 22'(ssel_r);
        ADDR_BAUD:   rdata_nxt = 22'(baud_r);
        ADDR_TXTH:   rdata_nxt = 22'(txth_r);
        ADDR_RXTH:   rdata_nxt = 22'(rxth_r);
        ADDR_TXLVL:  rdata_nxt = 22'(tx_count);
        ADDR_RXLVL:  rdata_nxt = 22'(rx_count);
        ADDR_STATUS: rdata_nxt = 22'({rx_count >= CW'(FIFO_DEPTH), rx_count == '0,
                                      tx_count == '0, tx_count >= CW'(FIFO_DEPTH),
                                      busy_r || tx_count != '0});
        ADDR_POL:    rdata_nxt = 22'(ipol_r);
        ADDR_MASK:   rdata_nxt = 22'(imask_r);
        ADDR_ISR:    rdata_nxt = 22'(raw & imask_r);
        ADDR_RISR:   rdata_nxt = 22'(raw);
        ADDR_RXDATA: begin
          // Pop; an empty FIFO reads zero and flags underflow.
          if (rx_count == '0) begin
            sticky_nxt[1] = 1'b1;
          end else begin
            rdata_nxt = 22'(rx_front);
            rx_pop    = 1'b1;
            rx_cnt_a  = CW'(rx_count - 1'b1);
          end
        end
        default: rdata_nxt = '0;
      endcase
    end else if (in_ch.command == CMD_WRITE) begin
      unique case (in_ch.address)
        ADDR_CTRL:   ctrl_nxt  = in_ch.write_data;
        ADDR_ENABLE: begin
          en_nxt = in_ch.write_data[0];
          if (!in_ch.write_data[0]) begin
            // Drop both FIFOs and abort the shifter.
            flush    = 1'b1;
            tx_cnt_a = '0;
            rx_cnt_a = '0;
            sw_nxt   = '0;
            bits_nxt = '0;
            cc_nxt   = '0;
            sclk_nxt = 1'b0;
            busy_nxt = 1'b0;
            held_nxt = 1'b0;
          end
        end
        ADDR_SSEL:   ssel_nxt  = in_ch.write_data[1:0] & SEL_MASK;
        ADDR_BAUD:   baud_nxt  = in_ch.write_data[15:0];
        ADDR_TXTH:   txth_nxt  = in_ch.write_data[4:0];
        ADDR_RXTH:   rxth_nxt  = in_ch.write_data[4:0];
        ADDR_POL:    ipol_nxt  = in_ch.write_data[0];
        ADDR_MASK:   imask_nxt = in_ch.write_data[4:0];
        ADDR_ICLR: begin
          if (in_ch.write_data[0]) sticky_nxt = '0;
          if (in_ch.write_data[1]) sticky_nxt[1] = 1'b0;
          if (in_ch.write_data[2]) sticky_nxt[2] = 1'b0;
          if (in_ch.write_data[3]) sticky_nxt[0] = 1'b0;
        end
        ADDR_TXDATA: begin
          if (en_r) begin
            if (tx_count >= CW'(FIFO_DEPTH)) begin
              sticky_nxt[0] = 1'b1;
            end else begin
              tx_push  = 1'b1;
              tx_cnt_a = CW'(tx_count + 1'b1);
            end
          end
        end
        default: ;
      endcase
    end

    // Shifter step on the updated registers.
    half  = baud_nxt[15:1];
    fmask = frame_mask(ctrl_nxt[1:0]);
    if (busy_nxt && half != '0) begin
      cc_nxt = 16'(cc_nxt + 1'b1);
      if (cc_nxt >= {1'b0, half}) begin
        cc_nxt = '0;
        if (!sclk_nxt) begin
          // Leading edge
          sclk_nxt = 1'b1;
          if (!ctrl_nxt[6]) begin
            held_nxt = in_ch.miso;
          end else if (bits_nxt < frame_len(ctrl_nxt[1:0])) begin
            sw_nxt = {sw_nxt[14:0], held_nxt} & fmask;
          end
        end else begin
          // Trailing edge
          sclk_nxt = 1'b0;
          if (!ctrl_nxt[6]) begin
            sw_nxt = {sw_nxt[14:0], held_nxt} & fmask;
          end else begin
            held_nxt = in_ch.miso;
            if (bits_nxt <= 5'd1) sw_nxt = {sw_nxt[14:0], held_nxt} & fmask;
          end
          bits_nxt = 5'(bits_nxt - 1'b1);
          if (bits_nxt == '0) begin
            d = sw_nxt & fmask;
            if (ctrl_nxt[12]) d = frame_rev(d, ctrl_nxt[1:0]);
            if (rx_cnt_a >= CW'(FIFO_DEPTH)) begin
              sticky_nxt[2] = 1'b1;
            end else begin
              rx_push = 1'b1;
            end
            busy_nxt = 1'b0;
          end
        end
      end
    end
    if (!busy_nxt && en_nxt && half != '0 && tx_cnt_a != '0) begin
      tx_pop   = 1'b1;
      sw_nxt   = ctrl_nxt[12] ? frame_rev(tx_front & fmask, ctrl_nxt[1:0]) : (tx_front & fmask);
      bits_nxt = frame_len(ctrl_nxt[1:0]);
      cc_nxt   = '0;
      sclk_nxt = 1'b0;
      busy_nxt = 1'b1;
    end
  end

  assign rx_wdata = d;
  assign tx_cnt_f = CW'(tx_cnt_a - CW'(tx_pop));
  assign rx_cnt_f = CW'(rx_cnt_a + CW'(rx_push));

  // Result fields from the state after the tick.
  always_comb begin
    logic [4:0] raw_f;
    raw_f[4]  = CMPW'(rx_cnt_f) > CMPW'(rxth_nxt);
    raw_f[3]  = sticky_nxt[2];
    raw_f[2]  = sticky_nxt[1];
    raw_f[1]  = sticky_nxt[0];
    raw_f[0]  = CMPW'(tx_cnt_f) <= CMPW'(txth_nxt);
    osclk_nxt = sclk_nxt ^ ctrl_nxt[7];
    omosi_nxt = busy_nxt && frame_msb(sw_nxt, ctrl_nxt[1:0]);
    ocs_nxt   = en_nxt ? ~ssel_nxt : 2'b11;
    oirq_nxt  = ((raw_f & imask_nxt) != '0) ^ ipol_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r   <= '0;
      en_r     <= 1'b0;
      ssel_r   <= '0;
      baud_r   <= '0;
      txth_r   <= '0;
      rxth_r   <= '0;
      imask_r  <= '0;
      ipol_r   <= 1'b0;
      sticky_r <= '0;
      sw_r     <= '0;
      bits_r   <= '0;
      cc_r     <= '0;
      sclk_r   <= 1'b0;
      busy_r   <= 1'b0;
      held_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (accept) begin
        // Advance state and load the result.
        ctrl_r   <= ctrl_nxt;
        en_r     <= en_nxt;
        ssel_r   <= ssel_nxt;
        baud_r   <= baud_nxt;
        txth_r   <= txth_nxt;
        rxth_r   <= rxth_nxt;
        imask_r  <= imask_nxt;
        ipol_r   <= ipol_nxt;
        sticky_r <= sticky_nxt;
        sw_r     <= sw_nxt;
        bits_r   <= bits_nxt;
        cc_r     <= cc_nxt;
        sclk_r   <= sclk_nxt;
        busy_r   <= busy_nxt;
        held_r   <= held_nxt;
        ovalid_r <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rdata_r <= rdata_nxt;
      osclk_r <= osclk_nxt;
      omosi_r <= omosi_nxt;
      ocs_r   <= ocs_nxt;
      oirq_r  <= oirq_nxt;
    end
  end

  assign out_ch.valid     = ovalid_r;
  assign out_ch.read_data = rdata_r;
  assign out_ch.sclk      = osclk_r;
  assign out_ch.mosi      = omosi_r;
  assign out_ch.cs_n      = ocs_r;
  assign out_ch.irq       = oirq_r;

endmodule
